// File: rtl/core/aligned_bump_allocator_with_peak_defines.svh
// Assertion macros for the aligned bump allocator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ALIGNED_BUMP_ALLOCATOR_WITH_PEAK_DEFINES_SVH
`define ALIGNED_BUMP_ALLOCATOR_WITH_PEAK_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ABAP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ABAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ABAP_ASSERT(lbl, clk, rstn, prop, msg)
`define ABAP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/core/abap_pkg.sv
// Shared types, constants and helper functions of the aligned bump allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package abap_pkg;

  // address arithmetic width of the window
  localparam int unsigned ADDR_BITS = 32;
  // width of config registers and payload fields
  localparam int unsigned DW = 32;
  // internal compare width: room for the widest operand plus carry and a spare bit
  localparam int unsigned CW = ((ADDR_BITS > DW) ? ADDR_BITS : DW) + 2;

  localparam logic [CW-1:0] AMAX      = (CW'(1) << ADDR_BITS) - CW'(1);
  localparam logic [CW-1:0] ALIGN_MAX = CW'(1) << (ADDR_BITS - 1);

  localparam logic [DW-1:0] MIN_ALIGN_RST = DW'(32);

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_RESET = 2'd1,
    FN_INIT  = 2'd2,
    FN_QUERY = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_ALIGN = 3'd2,
    ST_ZONE  = 3'd3,
    ST_WRAP  = 3'd4,
    ST_SPACE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_POOL_SIZE  = 2'd1,
    CFG_MIN_ALIGN  = 2'd2,
    CFG_ZONE_VALID = 2'd3
  } cfg_idx_e;

  // effective alignment from the normalizer
  typedef struct packed {
    logic [CW-1:0] align;
    logic          err;
  } align_t;

  // outcome of one request from the single-pass datapath
  typedef struct packed {
    status_e       status;
    logic [DW-1:0] addr;
    logic [DW-1:0] cons;
    logic [DW-1:0] off_nxt;
    logic          peak_clr;
  } res_t;

  function automatic logic [CW-1:0] zext(input logic [DW-1:0] x);
    return {{(CW-DW){1'b0}}, x};
  endfunction

  // smallest power of two >= v; 0 and 1 both give 1
  function automatic logic [CW-1:0] npow2(input logic [CW-1:0] v);
    logic [CW-1:0] t;
    t = v - CW'(1);
    for (int s = 1; s < CW; s = s * 2) begin
      t = t | (t >> s);
    end
    if (v <= CW'(1)) begin
      return CW'(1);
    end
    return t + CW'(1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/abap_align_norm.sv
// Alignment normalizer: raises the requested alignment to the minimum and
// rounds it up to a power of two. Depends on abap_pkg.
`default_nettype none

module abap_align_norm (
  input  logic [abap_pkg::DW-1:0] req_align_i,
  input  logic [abap_pkg::CW-1:0] min_pow2_i,
  output abap_pkg::align_t        norm_o
);
  import abap_pkg::*;

  logic [CW-1:0] raised;
  logic [CW-1:0] rounded;

  // min_pow2_i is already a power of two, so rounding the raised value covers
  // the doubling search from the minimum
  assign raised  = (zext(req_align_i) < min_pow2_i) ? min_pow2_i : zext(req_align_i);
  assign rounded = npow2(raised);

  assign norm_o.align = rounded;
  assign norm_o.err   = rounded > ALIGN_MAX;

endmodule

`default_nettype wire

// File: rtl/core/abap_alloc_calc.sv
// Single-pass request datapath: checks, pointer alignment and next offset.
// Depends on abap_pkg; fed by abap_align_norm and the state registers of the top.
`default_nettype none

module abap_alloc_calc (
  input  logic [1:0]              func_i,
  input  logic [abap_pkg::DW-1:0] req_size_i,
  input  abap_pkg::align_t        norm_i,
  input  logic [abap_pkg::DW-1:0] offset_i,
  input  logic [abap_pkg::DW-1:0] pool_base_i,
  input  logic [abap_pkg::DW-1:0] pool_size_i,
  input  logic                    zone_ok_i,
  output abap_pkg::res_t          res_o
);
  import abap_pkg::*;

  logic [CW-1:0] size_w, base_w, psize_w, off_w;
  logic [CW-1:0] amask, cur, aligned, new_off, new_end, cons;

  assign size_w  = zext(req_size_i);
  assign base_w  = zext(pool_base_i);
  assign psize_w = zext(pool_size_i);
  assign off_w   = zext(offset_i);

  assign amask   = norm_i.align - CW'(1);
  assign cur     = base_w + off_w;
  assign aligned = (cur + amask) & ~amask;
  assign new_off = aligned - base_w;
  assign new_end = new_off + size_w;
  assign cons    = new_end - off_w;

  always_comb begin
    res_o          = '0;
    res_o.status   = ST_OK;
    res_o.off_nxt  = offset_i;
    res_o.peak_clr = 1'b0;
    unique case (func_e'(func_i))
      FN_ALLOC: begin
        if (size_w == '0) begin
          res_o.status = ST_ZERO;
        end else if (norm_i.err) begin
          res_o.status = ST_ALIGN;
        end else if (!zone_ok_i || off_w > psize_w) begin
          res_o.status = ST_ZONE;
        end else if (off_w > AMAX - base_w || cur > AMAX - amask) begin
          res_o.status = ST_WRAP;
        end else if (new_off > psize_w || size_w > psize_w - new_off) begin
          res_o.status = ST_SPACE;
        end else begin
          res_o.addr    = aligned[DW-1:0];
          res_o.cons    = cons[DW-1:0];
          res_o.off_nxt = new_end[DW-1:0];
        end
      end
      FN_RESET: res_o.off_nxt = '0;
      FN_INIT: begin
        res_o.off_nxt  = '0;
        res_o.peak_clr = 1'b1;
      end
      FN_QUERY: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/aligned_bump_allocator_with_peak.sv
// Aligned bump allocator with peak tracking: top level with channels, state
// and config registers. Depends on abap_pkg, abap_align_norm, abap_alloc_calc.
//
// Use:
//   Requests arrive on the in channel (func_i, req_size_i, req_align_i) with
//   valid/ready; each request gives exactly one result on the out channel.
//   func: allocate, reset (offset cleared, peak kept), init (both cleared),
//   query. Every result carries status, address, consumed bytes and the used,
//   peak and free byte counts after the request.
//   Config writes (pool base, pool size, minimum alignment, zone valid) go
//   through the cfg channel, always ready; the user must make them only while idle (not enforced).
// Timing:
//   A request transfer loads the input register; when the item advances it is
//   computed in one pass and loaded into the result register, which raises
//   out_valid_o; a stalled result register delays the advance. One request per
//   cycle sustained while out_ready_i is high: the offset and peak registers are updated
//   by the same single pass that produces the result.
// Stall:
//   While out_ready_i is low the result holds; one more request waits in the
//   input register, then in_ready_o drops until the result transfer.
// Reset:
//   rst_ni clears both stages, offset and peak, and sets the config registers
//   to base 0, size 0, minimum alignment 32, zone invalid.
`default_nettype none

module aligned_bump_allocator_with_peak (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [abap_pkg::DW-1:0] cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic [abap_pkg::DW-1:0] req_size_i,
  input  logic [abap_pkg::DW-1:0] req_align_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic [abap_pkg::DW-1:0] alloc_addr_o,
  output logic [abap_pkg::DW-1:0] consumed_o,
  output logic [abap_pkg::DW-1:0] used_bytes_o,
  output logic [abap_pkg::DW-1:0] peak_bytes_o,
  output logic [abap_pkg::DW-1:0] free_bytes_o
);
  import abap_pkg::*;

`include "aligned_bump_allocator_with_peak_defines.svh"

  // config registers; minimum alignment is kept already rounded to a power of two
  logic [DW-1:0] pool_base_q, pool_size_q;
  logic [CW-1:0] min_pow2_q;
  logic          zone_valid_q;

  // input stage
  logic          in_valid_q;
  logic [1:0]    func_q;
  logic [DW-1:0] size_q, align_q;

  // state and result stage
  logic [DW-1:0] offset_q, peak_q, peak_d;
  logic          out_valid_q;
  status_e       status_q;
  logic [DW-1:0] addr_q, cons_q;

  logic          advance;
  logic          zone_ok;
  align_t        norm;
  res_t          res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_size_q  <= '0;
      min_pow2_q   <= npow2(zext(MIN_ALIGN_RST));
      zone_valid_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POOL_BASE:  pool_base_q  <= cfg_data_i;
        CFG_POOL_SIZE:  pool_size_q  <= cfg_data_i;
        CFG_MIN_ALIGN:  min_pow2_q   <= npow2(zext(cfg_data_i));
        CFG_ZONE_VALID: zone_valid_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign zone_ok = zone_valid_q && (pool_size_q != '0) && (zext(pool_base_q) <= AMAX)
                   && (zext(pool_size_q) <= AMAX - zext(pool_base_q));

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q  <= func_i;
      size_q  <= req_size_i;
      align_q <= req_align_i;
    end
  end

  abap_align_norm u_norm (
    .req_align_i (align_q),
    .min_pow2_i  (min_pow2_q),
    .norm_o      (norm)
  );

  abap_alloc_calc u_calc (
    .func_i      (func_q),
    .req_size_i  (size_q),
    .norm_i      (norm),
    .offset_i    (offset_q),
    .pool_base_i (pool_base_q),
    .pool_size_i (pool_size_q),
    .zone_ok_i   (zone_ok),
    .res_o       (res)
  );

  assign peak_d = res.peak_clr         ? '0          :
                  (res.off_nxt > peak_q) ? res.off_nxt : peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        offset_q    <= res.off_nxt;
        peak_q      <= peak_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= res.status;
      addr_q   <= res.addr;
      cons_q   <= res.cons;
    end
  end

  // offset and peak only move on advance, which also reloads the result,
  // so they read out directly as the counts after the shown item
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign alloc_addr_o = addr_q;
  assign consumed_o   = cons_q;
  assign used_bytes_o = offset_q;
  assign peak_bytes_o = peak_q;
  assign free_bytes_o = (zone_ok && offset_q < pool_size_q) ? (pool_size_q - offset_q) : '0;

  `ABAP_ASSERT(a_off_le_peak, clk_i, rst_ni, offset_q <= peak_q, "offset above peak")
  `ABAP_ASSERT_NEXT(a_peak_mono, clk_i, rst_ni, advance && func_e'(func_q) != FN_INIT, peak_q >= $past(peak_q), "peak dropped without init")
  `ABAP_ASSERT_NEXT(a_fail_keeps_off, clk_i, rst_ni, advance && func_e'(func_q) == FN_ALLOC && res.status != ST_OK, $stable(offset_q) && $stable(peak_q), "failed allocate moved state")
  `ABAP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q && $stable(func_q) && $stable(size_q) && $stable(align_q), "input stage lost a held item")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the aligned bump allocator with peak tracking.
// Needs abap_pkg and aligned_bump_allocator_with_peak; carries its own allocator model.

module tb_top;
  import abap_pkg::*;

  localparam int CLK_HALF_NS = 6;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] LAST_ADDR = (64'd1 << ADDR_BITS) - 64'd1;

  typedef struct packed {
    status_e     status;
    logic [31:0] addr;
    logic [31:0] cons;
    logic [31:0] used;
    logic [31:0] peak;
    logic [31:0] freeb;
  } alloc_res_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  cfg_idx_e    cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  func_e       func;
  logic [31:0] req_size;
  logic [31:0] req_align;
  logic        out_ready;

  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [31:0] alloc_addr_o;
  logic [31:0] consumed_o;
  logic [31:0] used_bytes_o;
  logic [31:0] peak_bytes_o;
  logic [31:0] free_bytes_o;

  // allocator model state and its copy of the registers
  logic [63:0] m_pool_base  = 64'd0;
  logic [63:0] m_pool_size  = 64'd0;
  logic [63:0] m_min_align  = 64'd32;
  logic        m_zone_valid = 1'b0;
  logic [63:0] m_offset     = 64'd0;
  logic [63:0] m_peak       = 64'd0;

  alloc_res_t  pending_results[$];
  int          mismatch_cnt = 0;
  bit          idle_en = 1'b1;
  int          hold_seq = 0;

  aligned_bump_allocator_with_peak u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .func_i       (func),
    .req_size_i   (req_size),
    .req_align_i  (req_align),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .status_o     (status_o),
    .alloc_addr_o (alloc_addr_o),
    .consumed_o   (consumed_o),
    .used_bytes_o (used_bytes_o),
    .peak_bytes_o (peak_bytes_o),
    .free_bytes_o (free_bytes_o)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic bit is_pow2(input logic [63:0] v);
    return (v != 64'd0) && ((v & (v - 64'd1)) == 64'd0);
  endfunction

  function automatic logic [63:0] pow2_ceil(input logic [63:0] v);
    logic [63:0] p;
    p = 64'd1;
    while (p < v && p <= (64'hFFFF_FFFF_FFFF_FFFF >> 1)) p = p << 1;
    return p;
  endfunction

  function automatic bit zone_usable();
    if (!m_zone_valid || m_pool_size == 64'd0 || m_pool_base > LAST_ADDR) return 1'b0;
    return m_pool_size <= LAST_ADDR - m_pool_base;
  endfunction

  // 1 and the effective alignment, or 0 on alignment overflow
  function automatic bit eff_align(input logic [63:0] req, output logic [63:0] a);
    logic [63:0] lo;
    logic [63:0] f;
    lo = pow2_ceil(m_min_align);
    a = (req < lo) ? lo : req;
    if (!is_pow2(a)) begin
      f = lo;
      while (f < a) begin
        if (f > (LAST_ADDR >> 1)) return 1'b0;
        f = f << 1;
      end
      a = f;
    end
    return a <= (LAST_ADDR >> 1) + 64'd1;
  endfunction

  function automatic alloc_res_t calc_alloc_result(input func_e f, input logic [31:0] sz,
                                                   input logic [31:0] al);
    alloc_res_t  r;
    logic [63:0] a;
    logic [63:0] cur;
    logic [63:0] aligned;
    logic [63:0] noff;
    logic [63:0] size;
    r = '0;
    r.status = ST_OK;
    size = {32'd0, sz};
    case (f)
      FN_ALLOC: begin
        if (size == 64'd0) r.status = ST_ZERO;
        else if (!eff_align({32'd0, al}, a)) r.status = ST_ALIGN;
        else if (!zone_usable() || m_offset > m_pool_size) r.status = ST_ZONE;
        else if (m_offset > LAST_ADDR - m_pool_base) r.status = ST_WRAP;
        else begin
          cur = m_pool_base + m_offset;
          if (cur > LAST_ADDR - (a - 64'd1)) r.status = ST_WRAP;
          else begin
            aligned = (cur + (a - 64'd1)) & ~(a - 64'd1);
            noff = aligned - m_pool_base;
            if (noff > m_pool_size || size > m_pool_size - noff) r.status = ST_SPACE;
            else begin
              r.addr = aligned[31:0];
              r.cons = 32'(noff + size - m_offset);
              m_offset = noff + size;
              if (m_offset > m_peak) m_peak = m_offset;
            end
          end
        end
      end
      FN_RESET: m_offset = 64'd0;
      FN_INIT: begin
        m_offset = 64'd0;
        m_peak = 64'd0;
      end
      default: ;
    endcase
    r.used = m_offset[31:0];
    r.peak = m_peak[31:0];
    if (zone_usable() && m_offset < m_pool_size) r.freeb = 32'(m_pool_size - m_offset);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_req(input func_e f, input logic [31:0] sz, input logic [31:0] al);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    req_size  <= sz;
    req_align <= al;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    pending_results.push_back(calc_alloc_result(f, sz, al));
  endtask

  // registers change only once the block has drained
  task automatic write_cfg(input logic [31:0] base, input logic [31:0] size,
                           input logic [31:0] min_al, input logic zv);
    logic [31:0] vals [4];
    vals = '{base, size, min_al, {31'd0, zv}};
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_e'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready_o) @(posedge clk);
      case (cfg_idx_e'(i))
        CFG_POOL_BASE: m_pool_base = {32'd0, vals[i]};
        CFG_POOL_SIZE: m_pool_size = {32'd0, vals[i]};
        CFG_MIN_ALIGN: m_min_align = {32'd0, vals[i]};
        default:       m_zone_valid = vals[i][0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic func_e rand_func();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return FN_ALLOC;
    if (sel < 16) return FN_RESET;
    if (sel < 17) return FN_INIT;
    return FN_QUERY;
  endfunction

  function automatic logic [31:0] rand_size();
    int unsigned sel;
    logic [31:0] cap;
    sel = $urandom_range(0, 19);
    cap = m_pool_size[31:0] >> 3;
    if (cap > 32'd4096) cap = 32'd4096;
    if (cap == 32'd0) cap = 32'd1;
    if (sel == 0) return 32'd0;
    if (sel == 1) return $urandom;
    if (sel < 5) return $urandom_range(1, 16);
    return $urandom_range(1, cap);
  endfunction

  function automatic logic [31:0] rand_align();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 32'd0;
    if (sel == 1) return $urandom;
    if (sel == 2) return 32'hFFFF_FFFF;
    if (sel < 6) return $urandom_range(1, 100);
    if (sel < 8) return 32'd1 << $urandom_range(13, 31);
    return 32'd1 << $urandom_range(0, 12);
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_req(rand_func(), rand_size(), rand_align());
  endtask

  task automatic rand_config();
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] min_al;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    base = (sel < 4) ? ($urandom & 32'hFFFF_F000) : (sel < 8) ? $urandom : 32'd0;
    sel = $urandom_range(0, 9);
    if (sel < 7) size = $urandom_range(32'h100, 32'h1_0000);
    else if (sel == 7) size = $urandom;
    else if (sel == 8) size = 32'hFFFF_FFFF - base;
    else size = 32'd0;
    sel = $urandom_range(0, 9);
    if (sel < 7) min_al = 32'd1 << $urandom_range(0, 8);
    else if (sel < 9) min_al = $urandom_range(0, 100);
    else min_al = 32'd1 << $urandom_range(9, 31);
    write_cfg(base, size, min_al, $urandom_range(0, 7) != 0);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : rx_proc
    int gap;
    int hold_seen;
    hold_seen = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        // long hold-off so the pipeline fills and in_ready_o drops
        hold_seen = hold_seq;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : chk_results
    alloc_res_t exp_r;
    logic       bad;
    if (rst_n === 1'b1 && out_valid_o === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < 10) $display("ERROR: result transfer with nothing pending");
        mismatch_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        bad = (status_o !== exp_r.status) || (alloc_addr_o !== exp_r.addr) ||
              (consumed_o !== exp_r.cons) || (used_bytes_o !== exp_r.used) ||
              (peak_bytes_o !== exp_r.peak) || (free_bytes_o !== exp_r.freeb);
        if (bad) begin
          if (mismatch_cnt < 10) begin
            $display("ERROR: exp st=%0d addr=%h cons=%h used=%h peak=%h free=%h",
                     exp_r.status, exp_r.addr, exp_r.cons, exp_r.used, exp_r.peak,
                     exp_r.freeb);
            $display("       got st=%0d addr=%h cons=%h used=%h peak=%h free=%h",
                     status_o, alloc_addr_o, consumed_o, used_bytes_o, peak_bytes_o,
                     free_bytes_o);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // registers at reset values: zone invalid, minimum alignment 32
  task automatic test_reset_state();
    send_req(FN_QUERY, 32'd0, 32'd0);
    send_req(FN_ALLOC, 32'd0, 32'd0);
    send_req(FN_ALLOC, 32'd16, 32'd0);
    send_req(FN_ALLOC, 32'd1, 32'hFFFF_FFFF);
  endtask

  task automatic test_alloc_basic();
    write_cfg(32'h0000_1000, 32'h0000_1000, 32'd32, 1'b1);
    send_req(FN_ALLOC, 32'd1, 32'd0);
    send_req(FN_ALLOC, 32'd100, 32'd3);
    send_req(FN_ALLOC, 32'hFFFF_FFFF, 32'd1);
    send_req(FN_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(FN_INIT, 32'd0, 32'd0);
    send_req(FN_ALLOC, 32'h0000_1000, 32'd1);
    send_req(FN_QUERY, 32'd0, 32'd0);
  endtask

  // non power of two minimums, minimum of zero, largest alignments
  task automatic test_align_rules();
    write_cfg(32'd0, 32'hFFFF_FFFF, 32'd24, 1'b1);
    send_req(FN_ALLOC, 32'd5, 32'd48);
    send_req(FN_ALLOC, 32'd1, 32'h8000_0000);
    send_req(FN_ALLOC, 32'd1, 32'h8000_0001);
    write_cfg(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_req(FN_INIT, 32'd0, 32'd0);
    send_req(FN_ALLOC, 32'hFFFF_FFFF, 32'd0);
    write_cfg(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_req(FN_ALLOC, 32'd1, 32'd1);
    write_cfg(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    send_req(FN_ALLOC, 32'd1, 32'd0);
  endtask

  task automatic test_zone_and_wrap();
    write_cfg(32'hFFFF_F000, 32'h0000_0FFF, 32'd1, 1'b1);
    send_req(FN_ALLOC, 32'd1, 32'h0001_0000);
    write_cfg(32'hFFFF_FFFF, 32'd1, 32'd1, 1'b1);
    send_req(FN_ALLOC, 32'd1, 32'd1);
    write_cfg(32'h0000_4000, 32'h0000_1000, 32'd8, 1'b0);
    send_req(FN_ALLOC, 32'd1, 32'd1);
  endtask

  // pool shrinks below the current offset
  task automatic test_shrunk_pool();
    write_cfg(32'd0, 32'h0001_0000, 32'd4, 1'b1);
    send_req(FN_ALLOC, 32'h0000_0800, 32'd0);
    write_cfg(32'd0, 32'h0000_0400, 32'd4, 1'b1);
    send_req(FN_ALLOC, 32'd1, 32'd0);
    send_req(FN_RESET, 32'd0, 32'd0);
    send_req(FN_ALLOC, 32'd1, 32'd0);
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 6; p++) begin
      rand_config();
      idle_en = ($urandom_range(0, 3) != 0);
      send_random(55);
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    write_cfg(32'h2000_0000, 32'h0010_0000, 32'd16, 1'b1);
    idle_en = 1'b0;
    hold_seq++;
    send_random(30);
    idle_en = 1'b1;
  endtask

  task automatic test_no_idle();
    rand_config();
    idle_en = 1'b0;
    send_random(60);
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_POOL_BASE;
    cfg_data  <= 32'd0;
    in_valid  <= 1'b0;
    func      <= FN_QUERY;
    req_size  <= 32'd0;
    req_align <= 32'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_alloc_basic();
    test_align_rules();
    test_zone_and_wrap();
    test_shrunk_pool();
    test_random_mix();
    test_backpressure();
    test_no_idle();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: aligned_bump_allocator_with_peak.f
+incdir+rtl/core
rtl/core/abap_pkg.sv
rtl/core/abap_align_norm.sv
rtl/core/abap_alloc_calc.sv
rtl/core/aligned_bump_allocator_with_peak.sv
tb/tb_top.sv
